### design/pbrt_pkg.sv
// Shared types and constants of the packet block receive tracker.
package pbrt_pkg;

  localparam int ID_W    = 63;
  localparam int SIZE_W  = 11;
  localparam int CNT_W   = 11;
  localparam int WIN_W   = 10;
  localparam int EPOCH_W = 8;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
  localparam logic [CNT_W-1:0]  CNT_MAX    = 11'd2047;

  localparam logic [1:0] KIND_MARK    = 2'd0;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] packet_id;
    logic            ack_any;
  } item_t;

  typedef struct packed {
    logic             prior_bit;
    logic             in_block;
    logic             is_full;
    logic [CNT_W-1:0] received_count;
    logic [ID_W-1:0]  current_block_start;
    logic [WIN_W-1:0] current_window_start;
  } result_t;

endpackage

### design/pbrt_ram.sv
// Generic single-port-write, registered-read RAM.
module pbrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/pbrt_div.sv
// Bit-serial restoring divider that yields the remainder of a packet id by the block size.
module pbrt_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pbrt_pkg::ID_W-1:0]   dividend,
  input  logic [pbrt_pkg::SIZE_W-1:0] divisor,
  output logic                        done,
  output logic [pbrt_pkg::SIZE_W-1:0] remainder
);

  localparam int STEP_W = $clog2(pbrt_pkg::ID_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(pbrt_pkg::ID_W - 1);

  logic                        busy;
  logic [STEP_W-1:0]           step;
  logic [pbrt_pkg::ID_W-1:0]   dvd;
  logic [pbrt_pkg::SIZE_W:0]   trial;
  logic                        fits;

  assign trial = {remainder, dvd[pbrt_pkg::ID_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign done  = busy && (step == LAST_STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == LAST_STEP) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      remainder <= '0;
    end else if (busy) begin
      dvd       <= {dvd[pbrt_pkg::ID_W-2:0], 1'b0};
      remainder <= fits ? pbrt_pkg::SIZE_W'(trial - {1'b0, divisor})
                        : trial[pbrt_pkg::SIZE_W-1:0];
    end
  end

endmodule

### design/packet_block_receive_tracker_top.sv
// Top level of the packet block receive tracker: sequencer, state registers and bitmap memory.
// A request is divided bit-serially by the block size to find its offset, is held while an
// earlier result still waits for result_ready, then reads the bitmap and updates the state.
// A new request is taken only once the sequencer is back in idle. Every 255th clearing of
// the bitmap adds a sweep over every bitmap address and a step that rewrites a pending mark.
// Synchronous reset; the bitmap is swept over every address before the first request.
module packet_block_receive_tracker_top #(
  parameter int MAX_BLOCK_BITS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  pbrt_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output pbrt_pkg::result_t           result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pbrt_pkg::SIZE_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_BLOCK_BITS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BLOCK_BITS - 1);
  localparam logic [16:0]   MAX_W     = 17'(MAX_BLOCK_BITS);
  localparam int TOT_W = pbrt_pkg::CNT_W + 2;

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_WAIT  = 8'b0000_1000,
    S_READ  = 8'b0001_0000,
    S_EXEC  = 8'b0010_0000,
    S_SWEEP = 8'b0100_0000,
    S_MARK  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [pbrt_pkg::SIZE_W-1:0]  block_size;
  logic [pbrt_pkg::SIZE_W-1:0]  size_eff;
  logic [pbrt_pkg::SIZE_W-1:0]  size_q;
  logic [1:0]                   kind_q;
  logic [pbrt_pkg::ID_W-1:0]    id_q;
  logic                         ack_q;
  logic                         pend_mark;

  logic [pbrt_pkg::ID_W-1:0]    block_first;
  logic [pbrt_pkg::SIZE_W-1:0]  window;
  logic [pbrt_pkg::CNT_W-1:0]   count;
  logic [pbrt_pkg::EPOCH_W-1:0] epoch;
  logic [AW-1:0]                sweep_addr;

  logic                         item_accept;
  logic                         div_done;
  logic [pbrt_pkg::SIZE_W-1:0]  off;
  logic [pbrt_pkg::ID_W-1:0]    start_id;
  logic [pbrt_pkg::EPOCH_W-1:0] ram_rdata;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [pbrt_pkg::EPOCH_W-1:0] ram_wdata;
  logic                         sweeping;

  logic                         bit_set;
  logic                         member;
  logic                         is_mark;
  logic                         is_restart;
  logic                         clr;
  logic                         wrap;
  logic                         bit_new;
  logic [pbrt_pkg::ID_W-1:0]    block_next;
  logic [pbrt_pkg::SIZE_W-1:0]  window_next;
  logic [pbrt_pkg::CNT_W-1:0]   count_base;
  logic [pbrt_pkg::CNT_W-1:0]   count_next;
  logic [pbrt_pkg::EPOCH_W-1:0] epoch_next;
  logic [TOT_W-1:0]             total;

  assign item_ready  = (state == S_IDLE);
  assign item_accept = item_valid && item_ready;
  assign cfg_ready   = 1'b1;

  always_comb begin
    if (block_size == '0) begin
      size_eff = pbrt_pkg::SIZE_W'(1);
    end else if ({6'b0, block_size} > MAX_W) begin
      size_eff = MAX_W[pbrt_pkg::SIZE_W-1:0];
    end else begin
      size_eff = block_size;
    end
  end

  pbrt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (item_accept),
    .dividend  (item.packet_id),
    .divisor   (size_q),
    .done      (div_done),
    .remainder (off)
  );

  assign start_id = id_q - pbrt_pkg::ID_W'(off);
  assign sweeping = (state == S_INIT) || (state == S_SWEEP);

  always_comb begin
    bit_set    = (ram_rdata == epoch);
    member     = (block_first == start_id);
    is_mark    = (kind_q == pbrt_pkg::KIND_MARK);
    is_restart = (kind_q == pbrt_pkg::KIND_RESTART);
    clr        = is_restart || (is_mark && (block_first != '0) && !member);
    wrap       = clr && (epoch == '1);
    bit_new    = is_mark && (clr || !bit_set);
    block_next = (is_mark || is_restart) ? start_id : block_first;
    if (is_restart || (is_mark && ack_q)) begin
      window_next = off;
    end else if (clr) begin
      window_next = '0;
    end else begin
      window_next = window;
    end
    count_base = clr ? '0 : count;
    count_next = (bit_new && (count_base != pbrt_pkg::CNT_MAX)) ? count_base + 1'b1
                                                                : count_base;
    if (wrap) begin
      epoch_next = pbrt_pkg::EPOCH_W'(1);
    end else if (clr) begin
      epoch_next = epoch + 1'b1;
    end else begin
      epoch_next = epoch;
    end
    total = TOT_W'(window_next) + TOT_W'(count_next)
          + TOT_W'((block_next == '0) && (window_next == '0));
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(off);
    ram_wdata = epoch_next;
    if (sweeping) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr;
      ram_wdata = '0;
    end else if (state == S_EXEC) begin
      ram_we = is_mark && !wrap;
    end else if (state == S_MARK) begin
      ram_we    = pend_mark;
      ram_wdata = epoch;
    end
  end

  pbrt_ram #(
    .WIDTH (pbrt_pkg::EPOCH_W),
    .DEPTH (MAX_BLOCK_BITS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (AW'(off)),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (sweep_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_accept) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!result_valid || result_ready) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = wrap ? S_SWEEP : S_IDLE;
      end
      S_SWEEP: begin
        if (sweep_addr == LAST_ADDR) begin
          state_next = S_MARK;
        end
      end
      S_MARK: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      sweep_addr   <= '0;
      epoch        <= pbrt_pkg::EPOCH_W'(1);
      block_first  <= '0;
      window       <= '0;
      count        <= '0;
      block_size   <= pbrt_pkg::SIZE_RESET;
      result_valid <= 1'b0;
      pend_mark    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        block_size <= cfg_data;
      end
      if (sweeping) begin
        sweep_addr <= (sweep_addr == LAST_ADDR) ? '0 : sweep_addr + 1'b1;
      end
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (state == S_EXEC) begin
        block_first  <= block_next;
        window       <= window_next;
        count        <= count_next;
        epoch        <= epoch_next;
        pend_mark    <= is_mark;
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      kind_q <= item.kind;
      id_q   <= item.packet_id;
      ack_q  <= item.ack_any;
      size_q <= size_eff;
    end
    if (state == S_EXEC) begin
      result.prior_bit            <= member && bit_set;
      result.in_block             <= member;
      result.is_full              <= total >= TOT_W'(size_q);
      result.received_count       <= count_next;
      result.current_block_start  <= block_next;
      result.current_window_start <= window_next[pbrt_pkg::WIN_W-1:0];
    end
  end

  a_epoch_nonzero: assert property (@(posedge clk) disable iff (rst)
    epoch != '0)
    else $error("bitmap epoch reached the swept tag value");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    {6'b0, count} <= MAX_W)
    else $error("received count exceeds the bitmap size");

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    {6'b0, window} < MAX_W)
    else $error("window start lies beyond the bitmap");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_EXEC)
    else $error("result raised outside the update cycle");

  a_wait_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> !result_valid)
    else $error("update started while the result register is occupied");

endmodule

### test/tb_packet_block_receive_tracker_top.sv
// Testbench of the packet block receive tracker with a predicting scoreboard.
`timescale 1ns / 100ps

module tb_packet_block_receive_tracker_top;

  localparam int MAX_BLOCK_BITS = 1024;
  localparam logic [1:0] KIND_TEST  = 2'd1;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [pbrt_pkg::ID_W-1:0] ID_MAX = '1;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_ready;
  pbrt_pkg::item_t item;
  logic result_valid;
  logic result_ready;
  pbrt_pkg::result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [pbrt_pkg::SIZE_W-1:0] cfg_data;

  packet_block_receive_tracker_top #(
    .MAX_BLOCK_BITS(MAX_BLOCK_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  class tracker_scoreboard;
    bit [MAX_BLOCK_BITS-1:0] seen_bits;
    logic [pbrt_pkg::ID_W-1:0] first_id;
    logic [pbrt_pkg::WIN_W-1:0] window;
    logic [pbrt_pkg::CNT_W-1:0] count;
    logic [pbrt_pkg::SIZE_W-1:0] size_reg;
    pbrt_pkg::result_t expected_q[$];
    int errors;

    function new();
      seen_bits = '0;
      first_id = '0;
      window = '0;
      count = '0;
      size_reg = pbrt_pkg::SIZE_RESET;
      errors = 0;
    endfunction

    function int unsigned effective_size();
      if (size_reg == 0) return 1;
      if (size_reg > MAX_BLOCK_BITS) return MAX_BLOCK_BITS;
      return 32'(size_reg);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(pbrt_pkg::item_t req);
      int unsigned eff;
      int unsigned off;
      int unsigned total;
      logic [pbrt_pkg::ID_W-1:0] start;
      logic member;
      logic prior;
      pbrt_pkg::result_t exp_r;
      eff = effective_size();
      start = req.packet_id / eff * eff;
      off = 32'(req.packet_id - start);
      member = (start == first_id);
      prior = member && seen_bits[off];
      case (req.kind)
        pbrt_pkg::KIND_MARK: begin
          if (first_id == 0) begin
            first_id = start;
          end else if (first_id != start) begin
            first_id = start;
            window = '0;
            count = '0;
            seen_bits = '0;
          end
          if (req.ack_any) window = pbrt_pkg::WIN_W'(off);
          if (!seen_bits[off]) begin
            seen_bits[off] = 1'b1;
            if (count != pbrt_pkg::CNT_MAX) count++;
          end
        end
        pbrt_pkg::KIND_RESTART: begin
          seen_bits = '0;
          first_id = start;
          window = pbrt_pkg::WIN_W'(off);
          count = '0;
        end
        default: ;
      endcase
      total = window + count + ((first_id == 0 && window == 0) ? 1 : 0);
      exp_r.prior_bit = prior;
      exp_r.in_block = member;
      exp_r.is_full = (total >= eff);
      exp_r.received_count = count;
      exp_r.current_block_start = first_id;
      exp_r.current_window_start = window;
      expected_q.push_back(exp_r);
    endfunction

    function void compare_field(string field, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s expected %0h actual %0h", $time, field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(pbrt_pkg::result_t got);
      pbrt_pkg::result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: result %0h arrived with no request outstanding", $time, got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("prior_bit", 64'(exp_r.prior_bit), 64'(got.prior_bit));
      compare_field("in_block", 64'(exp_r.in_block), 64'(got.in_block));
      compare_field("is_full", 64'(exp_r.is_full), 64'(got.is_full));
      compare_field("received_count", 64'(exp_r.received_count),
                    64'(got.received_count));
      compare_field("current_block_start", 64'(exp_r.current_block_start),
                    64'(got.current_block_start));
      compare_field("current_window_start", 64'(exp_r.current_window_start),
                    64'(got.current_window_start));
    endfunction
  endclass

  tracker_scoreboard sb = new();
  int burst_left = 0;
  logic [15:0] ready_pattern;
  int unsigned ready_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("packet_block_receive_tracker_top: mismatch");
    $finish;
  end

  initial begin
    result_ready = 1'b0;
    ready_pattern = '1;
    ready_cycles = 0;
    forever begin
      @(negedge clk);
      if (ready_cycles[7:0] == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pattern = '1;
          1: ready_pattern = 16'($urandom);
          2: ready_pattern = 16'($urandom & $urandom);
          default: ready_pattern = 16'h0001;
        endcase
      end
      result_ready = ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      ready_cycles++;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  function automatic logic [pbrt_pkg::ID_W-1:0] rand_id();
    logic [63:0] t;
    t = {$urandom, $urandom};
    return t[pbrt_pkg::ID_W-1:0];
  endfunction

  task automatic send_request(input pbrt_pkg::item_t req);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 8);
      @(negedge clk);
      item_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    @(negedge clk);
    item_valid = 1'b1;
    item = req;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_request(req);
    burst_left--;
  endtask

  task automatic send_fields(input logic [1:0] kind, input logic [pbrt_pkg::ID_W-1:0] id,
                             input logic ack);
    pbrt_pkg::item_t req;
    req.kind = kind;
    req.packet_id = id;
    req.ack_any = ack;
    send_request(req);
  endtask

  task automatic write_size(input logic [pbrt_pkg::SIZE_W-1:0] value);
    @(negedge clk);
    item_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.size_reg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly runs of marks and tests inside one block, opened by a restart or
  // by rolling into the next block, with some fully random requests mixed in.
  task automatic run_random_blocks(input logic [pbrt_pkg::SIZE_W-1:0] size_val,
                                   input int n_items);
    int unsigned eff;
    int sent;
    int len;
    int pick;
    logic [pbrt_pkg::ID_W-1:0] base;
    logic [pbrt_pkg::ID_W-1:0] blk;
    logic [pbrt_pkg::ID_W-1:0] id;
    write_size(size_val);
    eff = sb.effective_size();
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 3))
        0: base = pbrt_pkg::ID_W'($urandom_range(0, 3 * eff));
        1: base = rand_id();
        2: base = ID_MAX - $urandom_range(0, 2 * eff);
        default: base = pbrt_pkg::ID_W'({$urandom_range(0, 255), $urandom});
      endcase
      blk = base / eff * eff;
      if ($urandom_range(0, 3) != 0) begin
        send_fields(pbrt_pkg::KIND_RESTART, base, 1'($urandom_range(0, 1)));
        sent++;
      end
      len = $urandom_range(1, (eff < 20) ? 2 * eff + 4 : 40);
      repeat (len) begin
        pick = $urandom_range(0, 19);
        if (pick == 16 || pick == 17) blk = blk + eff;
        id = blk + $urandom_range(0, eff - 1);
        if (pick < 12 || pick == 16 || pick == 17) begin
          send_fields(pbrt_pkg::KIND_MARK, id, $urandom_range(0, 4) == 0);
        end else if (pick < 15) begin
          send_fields(KIND_TEST, id, 1'($urandom_range(0, 1)));
        end else if (pick == 15) begin
          send_fields(KIND_SPARE, id, 1'($urandom_range(0, 1)));
        end else begin
          send_fields(2'($urandom_range(0, 3)), rand_id(), 1'($urandom_range(0, 1)));
        end
        sent++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_size(pbrt_pkg::SIZE_RESET);
    send_fields(KIND_TEST, 0, 1'b0);
    send_fields(pbrt_pkg::KIND_MARK, 5, 1'b0);
    send_fields(pbrt_pkg::KIND_MARK, 5, 1'b1);
    // While the block start is zero, a mark in another block is adopted without clearing the bitmap.
    send_fields(pbrt_pkg::KIND_MARK, 1030, 1'b1);
    send_fields(KIND_TEST, 1029, 1'b0);
    send_fields(pbrt_pkg::KIND_MARK, 2051, 1'b0);
    send_fields(KIND_SPARE, 2051, 1'b1);
    send_fields(KIND_TEST, 2050, 1'b0);
    send_fields(pbrt_pkg::KIND_RESTART, ID_MAX, 1'b1);
    send_fields(pbrt_pkg::KIND_MARK, ID_MAX, 1'b1);
    send_fields(pbrt_pkg::KIND_MARK, ID_MAX - 1023, 1'b0);
    send_fields(KIND_TEST, 0, 1'b1);
    send_fields(pbrt_pkg::KIND_RESTART, 0, 1'b0);
    send_fields(pbrt_pkg::KIND_MARK, 1023, 1'b1);
    send_fields(pbrt_pkg::KIND_MARK, 0, 1'b1);
    send_fields(pbrt_pkg::KIND_RESTART, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0);
    send_fields(pbrt_pkg::KIND_MARK, 63'h5555_5555_5555_5555, 1'b1);
    send_fields(KIND_TEST, 63'h2AAA_AAAA_AAAA_AAAA, 1'b1);

    run_random_blocks(11'd8, 100);
    run_random_blocks(11'd0, 100);
    run_random_blocks(11'd1024, 100);
    run_random_blocks(11'd1, 100);
    run_random_blocks(11'd13, 100);
    run_random_blocks(11'd2047, 100);
    run_random_blocks(11'd3, 100);
    run_random_blocks(11'd700, 100);
    run_random_blocks(11'd64, 100);

    @(negedge clk);
    item_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("packet_block_receive_tracker_top: match");
    end else begin
      $display("packet_block_receive_tracker_top: mismatch");
    end
    $finish;
  end

endmodule
